// ----- design/e2r_pkg.sv -----
// Shared constants and helpers for the Euler angle to rotation matrix block.
package e2r_pkg;

   localparam int FRAC_BITS = 30;
   localparam int WORK_BITS = 34;
   localparam int PROD_BITS = 2 * WORK_BITS;

   typedef logic signed [WORK_BITS-1:0] work_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;

   localparam work_type HALF_PI = 34'sd1686629713;
   localparam work_type PI_VAL  = 34'sd3373259426;
   localparam work_type GAIN    = 34'sd652032874;

   function automatic work_type atan_entry(input int idx);
      work_type r;
      case (idx)
         0: r = 34'h03243F6A8;
         1: r = 34'h01DAC6705;
         2: r = 34'h00FADBAFC;
         3: r = 34'h007F56EA6;
         4: r = 34'h003FEAB76;
         5: r = 34'h001FFD55B;
         6: r = 34'h000FFFAAA;
         7: r = 34'h0007FFF55;
         8: r = 34'h0003FFFEA;
         9: r = 34'h0001FFFFD;
         10: r = 34'h0000FFFFF;
         11: r = 34'h00007FFFF;
         12: r = 34'h00003FFFF;
         13: r = 34'h00001FFFF;
         14: r = 34'h00000FFFF;
         15: r = 34'h000007FFF;
         16: r = 34'h000003FFF;
         17: r = 34'h000001FFF;
         18: r = 34'h000000FFF;
         19: r = 34'h0000007FF;
         20: r = 34'h0000003FF;
         21: r = 34'h0000001FF;
         22: r = 34'h0000000FF;
         23: r = 34'h00000007F;
         24: r = 34'h00000003F;
         25: r = 34'h00000001F;
         26: r = 34'h00000000F;
         27: r = 34'h000000008;
         28: r = 34'h000000004;
         29: r = 34'h000000002;
         30: r = 34'h000000001;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q4.30 product, rounded half up.
   function automatic work_type mul_q30(input work_type a, input work_type b);
      prod_type p;
      p = prod_type'(a) * prod_type'(b) + (prod_type'(1) <<< (FRAC_BITS - 1));
      return work_type'(p >>> FRAC_BITS);
   endfunction

endpackage

// ----- design/euler_to_rotation_matrix.sv -----
// Top level of the Euler angle to rotation matrix converter.
// Takes yaw, pitch and roll in Q3.13 radians and gives R = Rroll*Ryaw*Rpitch in
// Q1.14, saturated to plus or minus one. Three CORDIC lanes run side by side, one
// per angle, followed by a two-stage product array. One request is accepted every
// cycle while req_stall is low. The whole pipeline holds while the
// result stage is full and stalled, so results are never lost.
module euler_to_rotation_matrix
   import e2r_pkg::*;
#(
   parameter int ANGLE_BITS    = 16,
   parameter int ENTRY_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ANGLE_BITS-1:0] req_yaw_angle,
   input  logic signed [ANGLE_BITS-1:0] req_pitch_angle,
   input  logic signed [ANGLE_BITS-1:0] req_roll_angle,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [ENTRY_BITS-1:0] rsp_m00,
   output logic signed [ENTRY_BITS-1:0] rsp_m01,
   output logic signed [ENTRY_BITS-1:0] rsp_m02,
   output logic signed [ENTRY_BITS-1:0] rsp_m10,
   output logic signed [ENTRY_BITS-1:0] rsp_m11,
   output logic signed [ENTRY_BITS-1:0] rsp_m12,
   output logic signed [ENTRY_BITS-1:0] rsp_m20,
   output logic signed [ENTRY_BITS-1:0] rsp_m21,
   output logic signed [ENTRY_BITS-1:0] rsp_m22
);

   localparam int DEPTH = CORDIC_STAGES + 3;

   logic [DEPTH-1:0] valid_ff;
   logic             advance;
   work_type sz, cz, sy, cy, sx, cx;
   logic signed [ENTRY_BITS-1:0] entry [9];

   assign advance   = !(valid_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_valid};
      end
   end

   e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
      .clock(clock), .advance(advance), .angle(req_yaw_angle),
      .sin_out(sz), .cos_out(cz));
   e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
      .clock(clock), .advance(advance), .angle(req_pitch_angle),
      .sin_out(sy), .cos_out(cy));
   e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
      .clock(clock), .advance(advance), .angle(req_roll_angle),
      .sin_out(sx), .cos_out(cx));

   e2r_merge #(.ENTRY_BITS(ENTRY_BITS)) u_merge (
      .clock(clock), .advance(advance),
      .sz(sz), .cz(cz), .sy(sy), .cy(cy), .sx(sx), .cx(cx),
      .entry(entry));

   assign rsp_m00 = entry[0];
   assign rsp_m01 = entry[1];
   assign rsp_m02 = entry[2];
   assign rsp_m10 = entry[3];
   assign rsp_m11 = entry[4];
   assign rsp_m12 = entry[5];
   assign rsp_m20 = entry[6];
   assign rsp_m21 = entry[7];
   assign rsp_m22 = entry[8];

endmodule

// ----- design/e2r_cordic.sv -----
// Pipelined rotation-mode CORDIC lane giving sine and cosine of one angle.
module e2r_cordic
   import e2r_pkg::*;
#(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic [ANGLE_BITS-1:0] angle,
   output work_type              sin_out,
   output work_type              cos_out
);

   localparam int SHIFT = FRAC_BITS - (ANGLE_BITS - 3);

   work_type x_ff [CORDIC_STAGES+1];
   work_type y_ff [CORDIC_STAGES+1];
   work_type z_ff [CORDIC_STAGES+1];
   logic     neg_ff [CORDIC_STAGES+1];

   work_type z_wide;
   work_type z_fold_in;
   logic     neg_in;

   always_comb begin
      z_wide = work_type'($signed(angle)) <<< SHIFT;
      neg_in = 1'b0;
      z_fold_in = z_wide;
      if (z_wide > HALF_PI) begin
         z_fold_in = z_wide - PI_VAL;
         neg_in = 1'b1;
      end else if (z_wide < -HALF_PI) begin
         z_fold_in = z_wide + PI_VAL;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= z_fold_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (advance) begin
            neg_ff[i+1] <= neg_ff[i];
            if (!z_ff[i][WORK_BITS-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end
         end
      end
   end

   assign cos_out = neg_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
   assign sin_out = neg_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];

endmodule

// ----- design/e2r_merge.sv -----
// Product pipeline that combines the three lanes' sines and cosines into the matrix.
module e2r_merge
   import e2r_pkg::*;
#(
   parameter int ENTRY_BITS = 16
) (
   input  logic                         clock,
   input  logic                         advance,
   input  work_type                     sz,
   input  work_type                     cz,
   input  work_type                     sy,
   input  work_type                     cy,
   input  work_type                     sx,
   input  work_type                     cx,
   output logic signed [ENTRY_BITS-1:0] entry [9]
);

   localparam int SH = FRAC_BITS - (ENTRY_BITS - 2);

   // First stage: two-factor products; second: third factor and sums.
   work_type szcy_ff, szsy_ff, czcy_ff, czsy_ff, nsz_ff, cxcz_ff, sxcz_ff;
   work_type sxsy_ff, sxcy_ff, cxsy_ff, cxcy_ff, sx_ff, cx_ff;
   work_type sum_ff [9];

   always_ff @(posedge clock) begin
      if (advance) begin
         szcy_ff <= mul_q30(sz, cy);
         szsy_ff <= mul_q30(sz, sy);
         czcy_ff <= mul_q30(cz, cy);
         czsy_ff <= mul_q30(cz, sy);
         nsz_ff  <= -sz;
         cxcz_ff <= mul_q30(cx, cz);
         sxcz_ff <= mul_q30(sx, cz);
         sxsy_ff <= mul_q30(sx, sy);
         sxcy_ff <= mul_q30(sx, cy);
         cxsy_ff <= mul_q30(cx, sy);
         cxcy_ff <= mul_q30(cx, cy);
         sx_ff   <= sx;
         cx_ff   <= cx;
         sum_ff[0] <= czcy_ff;
         sum_ff[1] <= nsz_ff;
         sum_ff[2] <= czsy_ff;
         sum_ff[3] <= mul_q30(szcy_ff, cx_ff) + sxsy_ff;
         sum_ff[4] <= cxcz_ff;
         sum_ff[5] <= mul_q30(szsy_ff, cx_ff) - sxcy_ff;
         sum_ff[6] <= mul_q30(szcy_ff, sx_ff) - cxsy_ff;
         sum_ff[7] <= sxcz_ff;
         sum_ff[8] <= mul_q30(szsy_ff, sx_ff) + cxcy_ff;
      end
   end

   for (genvar k = 0; k < 9; k++) begin : g_out
      work_type r;
      work_type one;
      always_comb begin
         one = work_type'(1) <<< (ENTRY_BITS - 2);
         if (SH > 0) r = (sum_ff[k] + (work_type'(1) <<< (SH - 1))) >>> SH;
         else r = sum_ff[k];
         if (r > one) r = one;
         if (r < -one) r = -one;
         entry[k] = r[ENTRY_BITS-1:0];
      end
   end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the Euler angle to rotation matrix converter.
`timescale 1ns / 100ps

module testbench
   import e2r_pkg::*;
();

   localparam int LATENCY = 16 + 3;

   typedef struct packed {
      logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   } matrix_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_yaw_angle = '0;
   logic signed [15:0] req_pitch_angle = '0;
   logic signed [15:0] req_roll_angle = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [15:0] rsp_m20, rsp_m21, rsp_m22;

   matrix_type expected_matrices[$];
   int      error_count = 0;
   int      stall_left = 0;
   bit      gaps_on = 1'b1;
   bit      hold_rsp = 1'b0;

   always #2 clock = ~clock;

   euler_to_rotation_matrix u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_yaw_angle(req_yaw_angle), .req_pitch_angle(req_pitch_angle),
      .req_roll_angle(req_roll_angle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_m00(rsp_m00), .rsp_m01(rsp_m01), .rsp_m02(rsp_m02),
      .rsp_m10(rsp_m10), .rsp_m11(rsp_m11), .rsp_m12(rsp_m12),
      .rsp_m20(rsp_m20), .rsp_m21(rsp_m21), .rsp_m22(rsp_m22)
   );

   function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
      return v >>> s;
   endfunction

   function automatic logic signed [63:0] q30_product(logic signed [63:0] a,
                                                      logic signed [63:0] b);
      return floor_shift(a * b + (64'sd1 <<< 29), 30);
   endfunction

   // Rotation-mode CORDIC, folded into minus pi/2 to pi/2 first.
   task automatic sine_cosine(input logic signed [15:0] angle,
                              output logic signed [63:0] s,
                              output logic signed [63:0] c);
      logic signed [63:0] z, x, y, nx, step;
      bit flip;
      z = 64'(angle) <<< 17;
      x = 64'sd652032874;
      y = 0;
      flip = 1'b0;
      if (z > 64'sd1686629713) begin
         z = z - 64'sd3373259426;
         flip = 1'b1;
      end else if (z < -64'sd1686629713) begin
         z = z + 64'sd3373259426;
         flip = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         step = 64'(atan_entry(i));
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z = z - step;
         end else begin
            nx = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z = z + step;
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic signed [15:0] to_entry(logic signed [63:0] v);
      v = floor_shift(v + (64'sd1 <<< 15), 16);
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v[15:0];
   endfunction

   task automatic predict_matrix(input logic signed [15:0] yaw, pitch, roll,
                                 output matrix_type m);
      logic signed [63:0] sz, cz, sy, cy, sx, cx, szcy, szsy;
      sine_cosine(yaw, sz, cz);
      sine_cosine(pitch, sy, cy);
      sine_cosine(roll, sx, cx);
      szcy = q30_product(sz, cy);
      szsy = q30_product(sz, sy);
      m.m00 = to_entry(q30_product(cz, cy));
      m.m01 = to_entry(-sz);
      m.m02 = to_entry(q30_product(cz, sy));
      m.m10 = to_entry(q30_product(szcy, cx) + q30_product(sx, sy));
      m.m11 = to_entry(q30_product(cx, cz));
      m.m12 = to_entry(q30_product(szsy, cx) - q30_product(sx, cy));
      m.m20 = to_entry(q30_product(szcy, sx) - q30_product(cx, sy));
      m.m21 = to_entry(q30_product(sx, cz));
      m.m22 = to_entry(q30_product(szsy, sx) + q30_product(cx, cy));
   endtask

   // Offers one request, after an optional random gap, and waits until it is accepted.
   task automatic send_angles(input logic signed [15:0] yaw, pitch, roll);
      matrix_type m;
      int gap;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      predict_matrix(yaw, pitch, roll, m);
      req_valid <= 1'b1;
      req_yaw_angle <= yaw;
      req_pitch_angle <= pitch;
      req_roll_angle <= roll;
      expected_matrices.push_back(m);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_matrices.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] random_angle();
      return $urandom_range(0, 5) == 0 ? 16'($urandom) :
             16'(int'($urandom_range(0, 51472)) - 25736);
   endfunction

   task automatic test_directed();
      logic signed [15:0] corners[12] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
         -16'sd12868, 16'sd12869, -16'sd12869, 16'sd32767, 16'sh8000, 16'sd1,
         -16'sd1, 16'sd6434};
      for (int i = 0; i < 12; i++)
         send_angles(corners[i], corners[(i + 3) % 12], corners[(i + 7) % 12]);
      send_angles(16'sh5555, 16'shAAAA, 16'sh7FFF);
      send_angles(16'shAAAA, 16'sh5555, 16'sh8000);
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps going, so the pipeline fills.
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (60) send_angles(random_angle(), random_angle(), random_angle());
            idle_sender();
         end
         begin
            repeat (120) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join
      wait_drained();
   endtask

   task automatic test_random(input int count);
      repeat (count) send_angles(random_angle(), random_angle(), random_angle());
   endtask

   task automatic test_streaming();
      gaps_on = 1'b0;
      repeat (150) send_angles(random_angle(), random_angle(), random_angle());
      wait_drained();
   endtask

   // Random stalls come in bursts.
   always @(posedge clock) begin
      if (hold_rsp || !gaps_on) begin
         rsp_stall <= hold_rsp;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      matrix_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matrices.size() == 0) begin
            $error("result with no request outstanding");
            error_count++;
         end else begin
            e = expected_matrices.pop_front();
            if (rsp_m00 !== e.m00) begin
               $error("m00 exp %0d got %0d", e.m00, rsp_m00); error_count++;
            end
            if (rsp_m01 !== e.m01) begin
               $error("m01 exp %0d got %0d", e.m01, rsp_m01); error_count++;
            end
            if (rsp_m02 !== e.m02) begin
               $error("m02 exp %0d got %0d", e.m02, rsp_m02); error_count++;
            end
            if (rsp_m10 !== e.m10) begin
               $error("m10 exp %0d got %0d", e.m10, rsp_m10); error_count++;
            end
            if (rsp_m11 !== e.m11) begin
               $error("m11 exp %0d got %0d", e.m11, rsp_m11); error_count++;
            end
            if (rsp_m12 !== e.m12) begin
               $error("m12 exp %0d got %0d", e.m12, rsp_m12); error_count++;
            end
            if (rsp_m20 !== e.m20) begin
               $error("m20 exp %0d got %0d", e.m20, rsp_m20); error_count++;
            end
            if (rsp_m21 !== e.m21) begin
               $error("m21 exp %0d got %0d", e.m21, rsp_m21); error_count++;
            end
            if (rsp_m22 !== e.m22) begin
               $error("m22 exp %0d got %0d", e.m22, rsp_m22); error_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(1126);
      wait_drained();
      test_streaming();
      repeat (LATENCY + 5) @(posedge clock);
      if (error_count == 0 && expected_matrices.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   initial begin
      #400000;
      $display("testbench failed");
      $finish;
   end

endmodule

// ----- euler_to_rotation_matrix.f -----
design/e2r_pkg.sv
design/e2r_cordic.sv
design/e2r_merge.sv
design/euler_to_rotation_matrix.sv
tb/testbench.sv
